[rtl/core/lcdww_pkg.sv]
// Shared types, display command codes and state encodings for the LCD word-wrap block.
package lcdww_pkg;

  localparam logic [7:0] CHAR_SPACE       = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;

  localparam logic [7:0] CMD_LINE2        = 8'hC0;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_HOME_LINE1   = 8'h80;
  localparam logic [7:0] CMD_RETURN_HOME  = 8'h02;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

  localparam logic [2:0] SETUP_LAST       = 3'd6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPW         = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_INIT,
    OP_STORE,
    OP_SEND
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic       has_delim;
    logic       line_reset;
    logic       item_end;
  } op_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_INIT,
    F_DELIM,
    F_SPLIT,
    F_STORE,
    F_FINAL
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INIT,
    B_MOVE1,
    B_MOVE2,
    B_CHARS,
    B_DELIM
  } back_state_t;

  function automatic logic [7:0] setup_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CMD_CLEAR;
      3'd1:    b = CMD_RETURN_HOME;
      3'd2:    b = CMD_FUNCTION_SET;
      3'd3:    b = CMD_DISPLAY_ON;
      3'd4:    b = CMD_ENTRY_MODE;
      3'd5:    b = CMD_CLEAR;
      3'd6:    b = CMD_HOME_LINE1;
      default: b = CMD_HOME_LINE1;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/lcdww_if.sv]
// Valid/ready channel interfaces for message characters and display writes.
interface lcdww_msg_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] character;
  logic       message_end;

  modport source (output valid, output cmd, output character, output message_end, input ready);
  modport sink   (input valid, input cmd, input character, input message_end, output ready);
endinterface

interface lcdww_wr_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [7:0] byte_value;
  logic       run_end;

  modport source (output valid, output register_select, output byte_value, output run_end,
                  input ready);
  modport sink   (input valid, input register_select, input byte_value, input run_end,
                  output ready);
endinterface

[rtl/core/lcd_text_word_wrap.sv]
// Top level of the LCD word-wrap writer: front end, operation queue and back end.
// Front end: accepts a new message item only after the operations for the previous one are
//   queued, with an extra send on a word split or when a word character ends the message.
// Back end: pops each op in its idle state, then issues one write per cycle unless the
//   output is stalled (wr.ready low).
// Reset (rst, synchronous): control, counters and queue cleared; word store is not cleared.
module lcd_text_word_wrap import lcdww_pkg::*; #(
  parameter int LINE_CHARS = 16
) (
  input  logic         clk,
  input  logic         rst,
  lcdww_msg_if.sink    msg,
  lcdww_wr_if.source   wr
);

  logic push, full, pop, avail;
  op_t  push_op, pop_op;

  lcdww_front #(.LINE_CHARS(LINE_CHARS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg),
    .push    (push),
    .push_op (push_op),
    .full    (full)
  );

  lcdww_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .pop_op  (pop_op),
    .avail   (avail)
  );

  lcdww_back #(.LINE_CHARS(LINE_CHARS)) u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .op    (pop_op),
    .pop   (pop),
    .wr    (wr)
  );

endmodule

[rtl/core/lcdww_front.sv]
// Front end: accepts message items, classifies them and queues operations for the back end.
module lcdww_front import lcdww_pkg::*; #(
  parameter int LINE_CHARS = 16
) (
  input  logic         clk,
  input  logic         rst,
  lcdww_msg_if.sink    msg,
  output logic         push,
  output op_t          push_op,
  input  logic         full
);

  localparam int CW = $clog2(LINE_CHARS + 1);

  front_state_t   state, state_next;
  logic [CW-1:0]  fcount, fcount_next;
  logic [7:0]     chr;
  logic           last;
  logic           is_delim;

  assign is_delim = (msg.character == CHAR_SPACE) || (msg.character == CHAR_NEWLINE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      fcount <= '0;
    end else begin
      state  <= state_next;
      fcount <= fcount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      chr  <= msg.character;
      last <= msg.message_end;
    end
  end

  always_comb begin
    state_next         = state;
    fcount_next        = fcount;
    msg.ready          = 1'b0;
    push               = 1'b0;
    push_op.kind       = OP_SEND;
    push_op.data       = chr;
    push_op.has_delim  = 1'b0;
    push_op.line_reset = 1'b0;
    push_op.item_end   = 1'b1;
    case (state)
      F_IDLE: begin
        msg.ready = 1'b1;
        if (msg.valid) begin
          if (msg.cmd) begin
            state_next = F_INIT;
          end else if (is_delim) begin
            state_next = F_DELIM;
          end else if (fcount >= CW'(LINE_CHARS)) begin
            state_next = F_SPLIT;
          end else begin
            state_next = F_STORE;
          end
        end
      end
      F_INIT: begin
        push_op.kind = OP_INIT;
        push         = !full;
        if (!full) begin
          fcount_next = '0;
          state_next  = F_IDLE;
        end
      end
      F_DELIM: begin
        push_op.has_delim  = 1'b1;
        push_op.line_reset = last;
        push               = !full;
        if (!full) begin
          fcount_next = '0;
          state_next  = F_IDLE;
        end
      end
      F_SPLIT: begin
        // full buffer: flush it before the new character; the final send follows on message end
        push_op.item_end = !last;
        push             = !full;
        if (!full) begin
          fcount_next = '0;
          state_next  = F_STORE;
        end
      end
      F_STORE: begin
        push_op.kind = OP_STORE;
        push         = !full;
        if (!full) begin
          fcount_next = fcount + CW'(1);
          state_next  = last ? F_FINAL : F_IDLE;
        end
      end
      F_FINAL: begin
        push_op.line_reset = 1'b1;
        push               = !full;
        if (!full) begin
          fcount_next = '0;
          state_next  = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/lcdww_queue.sv]
// Small operation queue between the front and back ends.
module lcdww_queue import lcdww_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  pop_op,
  output logic avail
);

  op_t            entries [QUEUE_DEPTH];
  logic [QPW-1:0] wptr, rptr;
  logic [QPW:0]   used;

  assign full   = (used == (QPW+1)'(QUEUE_DEPTH));
  assign avail  = (used != '0);
  assign pop_op = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPW'(1);
      end
      if (pop) begin
        rptr <= rptr + QPW'(1);
      end
      if (push && !pop) begin
        used <= used + (QPW+1)'(1);
      end else if (pop && !push) begin
        used <= used - (QPW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_op;
    end
  end

endmodule

[rtl/core/lcdww_back.sv]
// Back end: word store, line tracking and sequencing of display writes.
module lcdww_back import lcdww_pkg::*; #(
  parameter int LINE_CHARS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         avail,
  input  op_t          op,
  output logic         pop,
  lcdww_wr_if.source   wr
);

  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam int IW = $clog2(LINE_CHARS);
  localparam int SW = CW + 1;

  back_state_t   state, state_next;
  logic [CW-1:0] bcount;
  logic [CW-1:0] pos;
  logic          line2;
  logic [2:0]    idx;
  logic [IW-1:0] k;

  logic          clr;
  logic [7:0]    delim;
  logic          delim_go;
  logic          line_reset;
  logic          item_end;

  logic [7:0]    store [LINE_CHARS];
  logic [7:0]    rd_data;
  logic [IW-1:0] rd_addr;

  logic          can_emit, emit, e_rs, e_end, done;
  logic [7:0]    e_byte;
  logic          move, delim_fit, char_last;
  logic [CW-1:0] base, cnt_m1;
  back_state_t   after_move;

  assign can_emit   = !wr.valid || wr.ready;
  assign move       = (({1'b0, pos} + {1'b0, bcount}) > SW'(LINE_CHARS))
                      || (pos == CW'(LINE_CHARS));
  assign base       = move ? '0 : pos;
  assign delim_fit  = ({1'b0, base} + {1'b0, bcount}) < SW'(LINE_CHARS);
  assign cnt_m1     = bcount - CW'(1);
  assign char_last  = (k == cnt_m1[IW-1:0]);
  assign after_move = (bcount != '0) ? B_CHARS : B_DELIM;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    e_rs       = 1'b0;
    e_byte     = '0;
    e_end      = 1'b0;
    done       = 1'b0;
    rd_addr    = '0;
    case (state)
      B_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          case (op.kind)
            OP_INIT:  state_next = B_INIT;
            OP_STORE: state_next = B_IDLE;
            OP_SEND: begin
              if (move) begin
                state_next = B_MOVE1;
              end else begin
                state_next = after_move;
              end
            end
            default:  state_next = B_IDLE;
          endcase
        end
      end
      B_INIT: begin
        emit   = can_emit;
        e_byte = setup_byte(idx);
        e_end  = (idx == SETUP_LAST);
        if (can_emit && idx == SETUP_LAST) begin
          state_next = B_IDLE;
        end
      end
      B_MOVE1: begin
        emit   = can_emit;
        e_byte = clr ? CMD_CLEAR : CMD_LINE2;
        if (can_emit) begin
          state_next = clr ? B_MOVE2 : after_move;
        end
      end
      B_MOVE2: begin
        emit   = can_emit;
        e_byte = CMD_HOME_LINE1;
        if (can_emit) begin
          state_next = after_move;
        end
      end
      B_CHARS: begin
        emit    = can_emit;
        e_rs    = 1'b1;
        e_byte  = rd_data;
        e_end   = char_last && !delim_go && item_end;
        rd_addr = k;
        if (can_emit) begin
          rd_addr = char_last ? '0 : k + IW'(1);
          if (char_last) begin
            state_next = delim_go ? B_DELIM : B_IDLE;
            done       = !delim_go;
          end
        end
      end
      B_DELIM: begin
        emit   = can_emit;
        e_rs   = 1'b1;
        e_byte = delim;
        e_end  = item_end;
        if (can_emit) begin
          state_next = B_IDLE;
          done       = 1'b1;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      bcount   <= '0;
      pos      <= '0;
      line2    <= 1'b0;
      idx      <= '0;
      k        <= '0;
      wr.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        wr.valid <= 1'b1;
      end else if (wr.ready) begin
        wr.valid <= 1'b0;
      end
      if (pop) begin
        case (op.kind)
          OP_INIT: begin
            bcount <= '0;
            pos    <= '0;
            line2  <= 1'b0;
            idx    <= '0;
          end
          OP_STORE: begin
            bcount <= bcount + CW'(1);
          end
          OP_SEND: begin
            pos <= base;
            k   <= '0;
            if (move) begin
              line2 <= !line2;
            end
          end
          default: begin
            bcount <= bcount;
          end
        endcase
      end
      if (emit && state == B_INIT) begin
        idx <= idx + 3'd1;
      end
      if (emit && state == B_CHARS) begin
        k <= k + IW'(1);
      end
      if (done) begin
        bcount <= '0;
      end
      if (done && line_reset) begin
        pos   <= '0;
        line2 <= 1'b0;
      end else if (emit && (state == B_CHARS || state == B_DELIM)) begin
        pos <= pos + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      wr.register_select <= e_rs;
      wr.byte_value      <= e_byte;
      wr.run_end         <= e_end;
    end
    if (pop && op.kind == OP_SEND) begin
      clr        <= line2;
      delim      <= op.data;
      delim_go   <= op.has_delim && delim_fit;
      line_reset <= op.line_reset;
      item_end   <= op.item_end;
    end
    if (pop && op.kind == OP_STORE) begin
      store[bcount[IW-1:0]] <= op.data;
    end
    rd_data <= store[rd_addr];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bcount <= CW'(LINE_CHARS))
    else $error("word count beyond line length");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= CW'(LINE_CHARS))
    else $error("line position beyond line length");

  a_chars_index: assert property (@(posedge clk) disable iff (rst)
    (state == B_CHARS) |-> (CW'(k) < bcount))
    else $error("character index outside buffered word");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    (pop && op.kind == OP_STORE) |-> (bcount < CW'(LINE_CHARS)))
    else $error("store into a full word buffer");

endmodule
